// File: design/ctef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctef_pkg;

  localparam int unsigned PixelWidth  = 8;
  localparam int unsigned RowWidth    = 12;
  localparam int unsigned PhaseWidth  = 3;
  localparam int unsigned PhaseCount  = 4;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDatWidth = 12;

  // register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] RegThreshOne   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegThreshTwo   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegThreshThree = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegThreshFour  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegPhases      = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegColumn      = 3'd5;

  localparam logic [PixelWidth-1:0]  ThreshOneReset   = 8'd200;
  localparam logic [PixelWidth-1:0]  ThreshTwoReset   = 8'd160;
  localparam logic [PixelWidth-1:0]  ThreshThreeReset = 8'd200;
  localparam logic [PixelWidth-1:0]  ThreshFourReset  = 8'd100;
  localparam logic [PhaseWidth-1:0]  PhasesReset      = 3'd4;
  localparam logic [RowWidth-1:0]    ColumnReset      = 12'd0;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel;
    logic                  last_in_column;
  } pixel_t;

  typedef struct packed {
    logic [RowWidth-1:0] column_out;
    logic [RowWidth-1:0] row_first;
    logic [RowWidth-1:0] row_second;
    logic [RowWidth-1:0] row_third;
    logic [RowWidth-1:0] row_fourth;
    logic                found_first;
    logic                found_second;
    logic                found_third;
    logic                found_fourth;
  } result_t;

endpackage

`default_nettype wire

// File: design/column_threshold_edge_finder_unit.sv
// Column threshold edge finder.
// Pixels of one image column enter top to bottom on the pixel channel
// (pixel_valid / pixel_stall / pixel_data), one transaction per cycle while pixel_stall is low.
// The block looks in turn for: a pixel above threshold one, then one below
// threshold two, then above three, then below four, recording each row.
// On the pixel flagged last_in_column one transaction leaves on the result
// channel with the column number, four rows and four found flags.
// Thresholds, phase count and column number are written on the cfg channel
// (cfg_valid / cfg_ready, always ready); the user must write them only while
// no column is in flight: the block does not enforce this. Throughput is
// one pixel per cycle while pixel_stall is low, set by the single compare
// and phase update in the scan stage. A result passes through the input
// register and is then loaded into the result register.
// When the receiver stalls, the result holds; further pixels keep flowing
// until the next last pixel reaches the input register, and then
// pixel_stall rises until the result is taken.
// Synchronous reset clears the column state and restores the register
// defaults; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module column_threshold_edge_finder_unit
  import ctef_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pixel_valid,
  output      logic                   pixel_stall,
  input  wire pixel_t                 pixel_data,
  output      logic                   result_valid,
  input  wire logic                   result_stall,
  output      result_t                result_data,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [CfgDatWidth-1:0] cfg_data
);

  localparam logic [RowWidth-1:0] RowCap =
    (MAX_ROWS > 4096) ? {RowWidth{1'b1}} : RowWidth'(MAX_ROWS - 1);

  logic [PixelWidth-1:0] thresh_one;
  logic [PixelWidth-1:0] thresh_two;
  logic [PixelWidth-1:0] thresh_three;
  logic [PixelWidth-1:0] thresh_four;
  logic [PhaseWidth-1:0] phases;
  logic [RowWidth-1:0]   column;

  logic   held_valid;
  pixel_t held;
  logic   held_fire;

  logic [RowWidth-1:0]   row_counter;
  logic [PhaseWidth-1:0] phase;
  logic [RowWidth-1:0]   found_rows [PhaseCount];

  logic [PhaseWidth-1:0] limit;
  logic                  match;
  logic [PhaseWidth-1:0] phase_next;
  logic [RowWidth-1:0]   found_rows_next [PhaseCount];
  result_t               result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_one   <= ThreshOneReset;
      thresh_two   <= ThreshTwoReset;
      thresh_three <= ThreshThreeReset;
      thresh_four  <= ThreshFourReset;
      phases       <= PhasesReset;
      column       <= ColumnReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegThreshOne:   thresh_one   <= cfg_data[PixelWidth-1:0];
        RegThreshTwo:   thresh_two   <= cfg_data[PixelWidth-1:0];
        RegThreshThree: thresh_three <= cfg_data[PixelWidth-1:0];
        RegThreshFour:  thresh_four  <= cfg_data[PixelWidth-1:0];
        RegPhases:      phases       <= cfg_data[PhaseWidth-1:0];
        RegColumn:      column       <= cfg_data[RowWidth-1:0];
        default: ;
      endcase
    end
  end

  // a last pixel may only leave the input register when the result slot is free
  assign held_fire   = held_valid &&
                       (!held.last_in_column || !result_valid || !result_stall);
  assign pixel_stall = held_valid && !held_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!pixel_stall) begin
      held_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_stall && pixel_valid) begin
      held <= pixel_data;
    end
  end

  always_comb begin
    limit = (phases > PhaseWidth'(PhaseCount)) ? PhaseWidth'(PhaseCount) : phases;
    case (phase)
      3'd0:    match = held.pixel > thresh_one;
      3'd1:    match = held.pixel < thresh_two;
      3'd2:    match = held.pixel > thresh_three;
      default: match = held.pixel < thresh_four;
    endcase
    phase_next = phase;
    for (int k = 0; k < PhaseCount; k++) begin
      found_rows_next[k] = found_rows[k];
    end
    if (phase < limit && match) begin
      found_rows_next[phase[1:0]] = row_counter;
      phase_next = phase + 3'd1;
    end
  end

  always_comb begin
    result_next.column_out   = column;
    result_next.row_first    = found_rows_next[0];
    result_next.row_second   = found_rows_next[1];
    result_next.row_third    = found_rows_next[2];
    result_next.row_fourth   = found_rows_next[3];
    result_next.found_first  = phase_next > 3'd0;
    result_next.found_second = phase_next > 3'd1;
    result_next.found_third  = phase_next > 3'd2;
    result_next.found_fourth = phase_next > 3'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      phase       <= '0;
      for (int k = 0; k < PhaseCount; k++) begin
        found_rows[k] <= '0;
      end
    end else if (held_fire) begin
      if (held.last_in_column) begin
        // clear for the next column
        row_counter <= '0;
        phase       <= '0;
        for (int k = 0; k < PhaseCount; k++) begin
          found_rows[k] <= '0;
        end
      end else begin
        if (row_counter < RowCap) begin
          row_counter <= row_counter + 12'd1;
        end
        phase <= phase_next;
        for (int k = 0; k < PhaseCount; k++) begin
          found_rows[k] <= found_rows_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (held_fire && held.last_in_column) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (held_fire && held.last_in_column) begin
      result_data <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/column_threshold_edge_finder_unit_tb.sv
`timescale 1ns / 1ps

module column_threshold_edge_finder_unit_tb;
  import ctef_pkg::*;

  localparam int unsigned RowCap     = 4095;
  localparam int unsigned Latency    = 2;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;

  typedef struct packed {
    pixel_t  item;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t Untyped = '0;
  localparam int unsigned DirRows = 25;

  // reset thresholds apply throughout: 200 above, 160 below, 200 above, 100 below
  localparam dir_row_t Directed [DirRows] = '{
    // lone bottom pixel: nothing found
    {8'd0,   1'b1, 1'b1, {12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'b0000}},
    // all four transitions on consecutive rows
    {8'd255, 1'b0, 1'b0, Untyped},
    {8'd0,   1'b0, 1'b0, Untyped},
    {8'd255, 1'b0, 1'b0, Untyped},
    {8'd0,   1'b1, 1'b1, {12'd0, 12'd0, 12'd1, 12'd2, 12'd3, 4'b1111}},
    // thresholds are strict; third phase never matches
    {8'd200, 1'b0, 1'b0, Untyped},
    {8'd201, 1'b0, 1'b0, Untyped},
    {8'd160, 1'b0, 1'b0, Untyped},
    {8'd159, 1'b0, 1'b0, Untyped},
    {8'd200, 1'b0, 1'b0, Untyped},
    {8'd100, 1'b1, 1'b1, {12'd0, 12'd1, 12'd3, 12'd0, 12'd0, 4'b1100}},
    // first phase fails, so dark pixels later do not count
    {8'd0,   1'b0, 1'b0, Untyped},
    {8'd150, 1'b0, 1'b0, Untyped},
    {8'd128, 1'b1, 1'b1, {12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'b0000}},
    // match on the bottom pixel itself
    {8'd99,  1'b0, 1'b0, Untyped},
    {8'd255, 1'b1, 1'b1, {12'd0, 12'd1, 12'd0, 12'd0, 12'd0, 4'b1000}},
    {8'd210, 1'b0, 1'b0, Untyped},
    {8'd210, 1'b0, 1'b0, Untyped},
    {8'd50,  1'b0, 1'b0, Untyped},
    {8'd220, 1'b0, 1'b0, Untyped},
    {8'd99,  1'b0, 1'b0, Untyped},
    {8'd255, 1'b1, 1'b0, Untyped},
    {8'd1,   1'b0, 1'b0, Untyped},
    {8'd254, 1'b0, 1'b0, Untyped},
    {8'd0,   1'b1, 1'b0, Untyped}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   pixel_valid;
  logic                   pixel_stall;
  pixel_t                 pixel_data;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [CfgDatWidth-1:0] cfg_data;

  // scan model: register copies and column state
  logic [PixelWidth-1:0] thresh [PhaseCount];
  logic [PhaseWidth-1:0] phases_reg;
  logic [RowWidth-1:0]   column_reg;
  logic [RowWidth-1:0]   row_ctr;
  int unsigned           phases_done;
  logic [RowWidth-1:0]   found_rows [PhaseCount];

  result_t     reports_due [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  int unsigned hold_req = 0;

  column_threshold_edge_finder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_data   (pixel_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void clear_column();
    row_ctr = '0;
    phases_done = 0;
    for (int k = 0; k < PhaseCount; k++) found_rows[k] = '0;
  endfunction

  function automatic void reset_model();
    thresh[RegThreshOne]   = ThreshOneReset;
    thresh[RegThreshTwo]   = ThreshTwoReset;
    thresh[RegThreshThree] = ThreshThreeReset;
    thresh[RegThreshFour]  = ThreshFourReset;
    phases_reg = PhasesReset;
    column_reg = ColumnReset;
    clear_column();
  endfunction

  function automatic void write_model_reg(input logic [CfgIdxWidth-1:0] idx,
                                          input logic [CfgDatWidth-1:0] data);
    case (idx)
      RegThreshOne, RegThreshTwo, RegThreshThree, RegThreshFour: begin
        thresh[idx] = data[PixelWidth-1:0];
      end
      RegPhases: phases_reg = data[PhaseWidth-1:0];
      RegColumn: column_reg = data[RowWidth-1:0];
      default: ;
    endcase
  endfunction

  // advance the column scan by one pixel; returns 1 when a report is due
  function automatic bit scan_pixel(input pixel_t p, output result_t rep);
    int unsigned limit;
    bit hit;
    limit = (phases_reg > PhaseCount) ? PhaseCount : phases_reg;
    rep = '0;
    if (phases_done < limit) begin
      // even phases look for a bright pixel, odd phases for a dark one
      hit = phases_done[0] ? (p.pixel < thresh[phases_done])
                           : (p.pixel > thresh[phases_done]);
      if (hit) begin
        found_rows[phases_done] = row_ctr;
        phases_done++;
      end
    end
    if (!p.last_in_column) begin
      if (row_ctr < RowCap) row_ctr++;
      return 1'b0;
    end
    rep.column_out   = column_reg;
    rep.row_first    = found_rows[0];
    rep.row_second   = found_rows[1];
    rep.row_third    = found_rows[2];
    rep.row_fourth   = found_rows[3];
    rep.found_first  = phases_done > 0;
    rep.found_second = phases_done > 1;
    rep.found_third  = phases_done > 2;
    rep.found_fourth = phases_done > 3;
    clear_column();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_report(input result_t got);
    result_t want;
    if (reports_due.size() == 0) begin
      $error("column report with none outstanding: column_out %0d", got.column_out);
      mismatch_count++;
      return;
    end
    want = reports_due.pop_front();
    check_field("column_out", want.column_out, got.column_out);
    check_field("row_first", want.row_first, got.row_first);
    check_field("row_second", want.row_second, got.row_second);
    check_field("row_third", want.row_third, got.row_third);
    check_field("row_fourth", want.row_fourth, got.row_fourth);
    check_field("found_first", want.found_first, got.found_first);
    check_field("found_second", want.found_second, got.found_second);
    check_field("found_third", want.found_third, got.found_third);
    check_field("found_fourth", want.found_fourth, got.found_fourth);
  endfunction

  function automatic logic [PixelWidth-1:0] rand_level(input int unsigned lo,
                                                       input int unsigned hi);
    return PixelWidth'($urandom_range(hi, lo));
  endfunction

  function automatic logic [PixelWidth-1:0] pick_shade();
    case ($urandom_range(3))
      0: return rand_level(0, 40);
      1: return rand_level(215, 255);
      default: return rand_level(0, 255);
    endcase
  endfunction

  task automatic offer_pixel(input pixel_t p, input bit typed, input result_t typed_want);
    result_t rep;
    if (!calm && $urandom_range(99) < 15) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_data  <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    if (scan_pixel(p, rep)) reports_due = {reports_due, typed ? typed_want : rep};
  endtask

  task automatic send_column(input int unsigned len);
    pixel_t p;
    for (int unsigned r = 0; r < len; r++) begin
      p.pixel = pick_shade();
      p.last_in_column = (r == len - 1);
      offer_pixel(p, 1'b0, Untyped);
    end
  endtask

  // let every outstanding report arrive, then leave the pipeline empty
  task automatic drain();
    pixel_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (Latency + 3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [PixelWidth-1:0] t1, t2, t3, t4,
                              input logic [PhaseWidth-1:0] ph,
                              input logic [RowWidth-1:0] col);
    logic [CfgDatWidth-1:0] vals [RegColumn + 1];
    vals[RegThreshOne]   = CfgDatWidth'(t1);
    vals[RegThreshTwo]   = CfgDatWidth'(t2);
    vals[RegThreshThree] = CfgDatWidth'(t3);
    vals[RegThreshFour]  = CfgDatWidth'(t4);
    vals[RegPhases]      = CfgDatWidth'(ph);
    vals[RegColumn]      = col;
    for (int i = 0; i <= RegColumn; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CfgIdxWidth'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      write_model_reg(CfgIdxWidth'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_setting(input logic [PixelWidth-1:0] t1, t2, t3, t4,
                             input logic [PhaseWidth-1:0] ph,
                             input logic [RowWidth-1:0] col,
                             input int unsigned quota, input bit steady, input bit squeeze);
    int unsigned sent;
    int unsigned len;
    drain();
    program_regs(t1, t2, t3, t4, ph, col);
    calm = steady;
    if (squeeze) hold_req++;
    sent = 0;
    while (sent < quota) begin
      if (squeeze) len = $urandom_range(1, 3);
      else if ($urandom_range(9) == 0) len = $urandom_range(20, 60);
      else len = $urandom_range(1, 12);
      send_column(len);
      sent += len;
    end
    calm = 1'b0;
  endtask

  // result side: random stall, long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_taken;
    hold_left = 0;
    hold_taken = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) check_report(result_data);
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("column_threshold_edge_finder_unit_tb: errors");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    pixel_valid <= 1'b0;
    pixel_data  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      offer_pixel(Directed[i].item, Directed[i].typed, Directed[i].want);
    end

    run_setting(8'd200, 8'd160, 8'd200, 8'd100, 3'd4, 12'd7, 150, 1'b0, 1'b0);
    // two-point ear scan
    run_setting(8'd200, 8'd50, 8'd200, 8'd100, 3'd2, 12'd4095, 100, 1'b1, 1'b0);
    run_setting(8'd0, 8'd255, 8'd0, 8'd255, 3'd4, 12'd1, 90, 1'b0, 1'b0);
    run_setting(8'd255, 8'd0, 8'd255, 8'd0, 3'd4, 12'd2048, 60, 1'b0, 1'b0);
    run_setting(rand_level(0, 255), rand_level(0, 255), rand_level(0, 255),
                rand_level(0, 255), 3'd0, 12'hABC, 60, 1'b0, 1'b0);
    run_setting(rand_level(0, 255), rand_level(0, 255), rand_level(0, 255),
                rand_level(0, 255), 3'd7, 12'h555, 90, 1'b0, 1'b0);
    run_setting(rand_level(0, 255), rand_level(0, 255), rand_level(0, 255),
                rand_level(0, 255), 3'd5, 12'h2AA, 90, 1'b0, 1'b0);
    run_setting(rand_level(100, 230), rand_level(30, 160), 8'd128, 8'd128,
                3'd1, 12'd100, 90, 1'b0, 1'b0);
    run_setting(rand_level(100, 230), rand_level(30, 160), rand_level(100, 230),
                rand_level(30, 160), 3'd3, 12'd1234, 90, 1'b0, 1'b0);
    // hold the result side so the block backs up onto the pixel side
    run_setting(8'd200, 8'd160, 8'd200, 8'd100, 3'd4, 12'd33, 60, 1'b1, 1'b1);

    drain();
    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("column_threshold_edge_finder_unit_tb: clean");
    end else begin
      $display("column_threshold_edge_finder_unit_tb: errors");
    end
    $finish;
  end

endmodule
